// ===== sv/pmfs_pkg.sv =====
// pmfs_pkg: constants and the per-channel shading function for the particle
// motion/fade step block. No dependencies; imported by the top level and its
// checker.
package pmfs_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned BRIGHT_W = 16;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PROD_W   = CHAN_W + BRIGHT_W + 1;
  localparam int unsigned DIST_W   = BRIGHT_W + 1;

  localparam logic [BRIGHT_W-1:0]     FADE_STEP  = 16'd8;
  localparam logic signed [DIST_W-1:0] NEAR_LIMIT = 17'sd16;
  localparam logic signed [PROD_W-1:0] SHADE_BIAS = 25'sd255;

  typedef logic signed [POS_W-1:0]    pos_t;
  typedef logic signed [BRIGHT_W-1:0] bright_t;
  typedef logic [COLOR_W-1:0]         color_t;
  typedef logic [CHAN_W-1:0]          chan_t;

  // channel * brightness / 256, truncated toward zero, low byte kept
  function automatic chan_t shade_chan(input chan_t ch, input bright_t b);
    logic signed [PROD_W-1:0] p;
    p = $signed({1'b0, ch}) * b;
    // bias negative products so the floor shift truncates toward zero
    if (p[PROD_W-1]) begin
      p = p + SHADE_BIAS;
    end
    return p[CHAN_W+7:8];
  endfunction

endpackage

// ===== sv/particle_motion_fade_step_top.sv =====
// particle_motion_fade_step_top: one update step of a fading particle.
// Depends on pmfs_pkg (widths, constants, shade_chan).
//
// Usage:
//   Drive the in_* fields with start high; the beat is taken on any rising
//   edge where start is high and busy is low. busy is high while rst_n is low
//   and for the first cycle after reset, so a new beat can be taken every cycle.
//   Each beat gives exactly one result on the out_* ports, shown for one
//   cycle with out_valid high; out_valid rises at the edge after the accepting
//   edge, when the result register loads.
//   Two register stages (input register, then result register). Throughput:
//   one item per cycle; the three position adds, three velocity adds and the
//   three 8x16 shading multiplies all sit between the two register stages.
//   The result channel has no backpressure: the receiver must take out_*
//   in the cycle that out_valid is high.
//   Reset (rst_n low, synchronous) drops any items in flight and clears
//   out_valid. The block keeps no state between items.
module particle_motion_fade_step_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  pmfs_pkg::pos_t           in_pos_x,
  input  pmfs_pkg::pos_t           in_pos_y,
  input  pmfs_pkg::pos_t           in_pos_z,
  input  pmfs_pkg::pos_t           in_vel_x,
  input  pmfs_pkg::pos_t           in_vel_y,
  input  pmfs_pkg::pos_t           in_vel_z,
  input  pmfs_pkg::pos_t           in_acc_x,
  input  pmfs_pkg::pos_t           in_acc_y,
  input  pmfs_pkg::pos_t           in_acc_z,
  input  pmfs_pkg::bright_t        in_brightness,
  input  pmfs_pkg::color_t         in_base_color,
  input  pmfs_pkg::bright_t        in_target_level,
  output logic                     out_valid,
  output pmfs_pkg::pos_t           out_new_pos_x,
  output pmfs_pkg::pos_t           out_new_pos_y,
  output pmfs_pkg::pos_t           out_new_pos_z,
  output pmfs_pkg::pos_t           out_new_vel_x,
  output pmfs_pkg::pos_t           out_new_vel_y,
  output pmfs_pkg::pos_t           out_new_vel_z,
  output pmfs_pkg::bright_t        out_new_brightness,
  output pmfs_pkg::color_t         out_shaded_color,
  output logic                     out_near_target,
  output logic                     out_faded_out,
  output logic                     out_finished
);
  import pmfs_pkg::*;

  logic    busy_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic    s2_valid_r;
  logic    accept;

  pos_t    px_r, py_r, pz_r, vx_r, vy_r, vz_r, ax_r, ay_r, az_r;
  bright_t bright_r, target_r;
  color_t  color_r;

  pos_t    npx_nxt, npy_nxt, npz_nxt, nvx_nxt, nvy_nxt, nvz_nxt;
  bright_t nb_nxt;
  color_t  shaded_nxt;
  logic    near_nxt, faded_nxt;
  logic signed [DIST_W-1:0] tgt_diff;

  pos_t    npx_r, npy_r, npz_r, nvx_r, nvy_r, nvz_r;
  bright_t nb_r;
  color_t  shaded_r;
  logic    near_r, faded_r;

  assign accept       = start && !busy_r;
  assign s1_valid_nxt = accept;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r     <= in_pos_x;
      py_r     <= in_pos_y;
      pz_r     <= in_pos_z;
      vx_r     <= in_vel_x;
      vy_r     <= in_vel_y;
      vz_r     <= in_vel_z;
      ax_r     <= in_acc_x;
      ay_r     <= in_acc_y;
      az_r     <= in_acc_z;
      bright_r <= in_brightness;
      color_r  <= in_base_color;
      target_r <= in_target_level;
    end
  end

  always_comb begin
    npx_nxt = px_r + vx_r;
    npy_nxt = py_r + vy_r;
    npz_nxt = pz_r + vz_r;
    nvx_nxt = vx_r + ax_r;
    nvy_nxt = vy_r + ay_r;
    nvz_nxt = vz_r + az_r;

    // signed distance between target and integer part of new x
    tgt_diff = DIST_W'(target_r) - DIST_W'($signed(npx_nxt[POS_W-1:POS_W-BRIGHT_W]));
    near_nxt = (tgt_diff < NEAR_LIMIT) && (tgt_diff > -NEAR_LIMIT);

    shaded_nxt = {shade_chan(color_r[23:16], bright_r),
                  shade_chan(color_r[15:8], bright_r),
                  shade_chan(color_r[7:0], bright_r)};

    nb_nxt    = bright_t'(bright_r - FADE_STEP);
    faded_nxt = nb_nxt[BRIGHT_W-1] || (nb_nxt == '0);
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      npx_r    <= npx_nxt;
      npy_r    <= npy_nxt;
      npz_r    <= npz_nxt;
      nvx_r    <= nvx_nxt;
      nvy_r    <= nvy_nxt;
      nvz_r    <= nvz_nxt;
      nb_r     <= nb_nxt;
      shaded_r <= shaded_nxt;
      near_r   <= near_nxt;
      faded_r  <= faded_nxt;
    end
  end

  assign busy               = busy_r;
  assign out_valid          = s2_valid_r;
  assign out_new_pos_x      = npx_r;
  assign out_new_pos_y      = npy_r;
  assign out_new_pos_z      = npz_r;
  assign out_new_vel_x      = nvx_r;
  assign out_new_vel_y      = nvy_r;
  assign out_new_vel_z      = nvz_r;
  assign out_new_brightness = nb_r;
  assign out_shaded_color   = shaded_r;
  assign out_near_target    = near_r;
  assign out_faded_out      = faded_r;
  assign out_finished       = near_r || faded_r;

endmodule

// ===== sv/pmfs_checker.sv =====
// pmfs_checker: port-level checks on the particle motion/fade step block,
// bound to particle_motion_fade_step_top. Depends on pmfs_pkg.
module pmfs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input pmfs_pkg::bright_t in_brightness,
  input logic              out_valid,
  input pmfs_pkg::bright_t out_new_brightness,
  input logic              out_near_target,
  input logic              out_faded_out,
  input logic              out_finished
);
  import pmfs_pkg::*;

  // every accepted beat shows up as a result
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted beat produced no result");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without accepted beat");

  // brightness follows the beat it came from
  a_fade: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_brightness == bright_t'($past(in_brightness, 2) - FADE_STEP)))
    else $error("new brightness mismatch");

  a_faded_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_faded_out == (out_new_brightness[BRIGHT_W-1] ||
                                     (out_new_brightness == '0))))
    else $error("faded flag mismatch");

  a_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_finished == (out_near_target || out_faded_out)))
    else $error("finished flag mismatch");

endmodule

bind particle_motion_fade_step_top pmfs_checker u_pmfs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_brightness      (in_brightness),
  .out_valid          (out_valid),
  .out_new_brightness (out_new_brightness),
  .out_near_target    (out_near_target),
  .out_faded_out      (out_faded_out),
  .out_finished       (out_finished)
);
